>>> hdl/cpc_pkg.sv
// ============================================================================
// cpc_pkg: shared constants and types for the circle pixel counter
// Field widths, datapath widths of the shared compare-subtract unit, the
// register index codes and the result record passed to the output stage.
// ============================================================================
package cpc_pkg;

    // Radius bits that take part in the height computation
    localparam int RADIUS_BITS = 32;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int HEIGHT_W  = 33;
    localparam int CFG_IDX_W = 1;

    // Dividend of the modulo step: running sum plus one column height
    localparam int DV_W      = HEIGHT_W + 1;
    localparam int MOD_STEPS = DV_W;
    localparam int DBL_STEPS = 2;

    // Remainder register serves both the root and the modulo steps
    localparam int REM_W  = (RADIUS_BITS + 1 > DATA_W) ? RADIUS_BITS + 1 : DATA_W;
    localparam int CSUB_W = REM_W + 2;

    // Step counter holds the longest step count minus one
    localparam int CNT_W = $clog2(MOD_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b1;

    // One finished column
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [DATA_W-1:0]   total;
        logic                last;
    } cpc_result_t;

endpackage

>>> hdl/cpc_csub.sv
// ============================================================================
// cpc_csub: shared compare-subtract unit
// Gives a - b and whether a >= b. Used for the square root digit steps,
// the modulo reduction steps and the final doublings.
// ============================================================================
module cpc_csub (
    input  logic [cpc_pkg::CSUB_W-1:0] a,
    input  logic [cpc_pkg::CSUB_W-1:0] b,
    output logic                       ge,
    output logic [cpc_pkg::CSUB_W-1:0] diff
);
    import cpc_pkg::*;

    logic [CSUB_W:0] wide_diff;

    // One extra bit carries the borrow
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[CSUB_W];
    assign diff      = wide_diff[CSUB_W-1:0];

endmodule

>>> hdl/cpc_seq.sv
// ============================================================================
// cpc_seq: column height and running sum sequencer
// Takes one column at a time: squares difference via (r-x)(r+x), runs a
// two-bits-per-step integer square root, rounds up, then reduces the sum
// modulo k one bit per step and doubles twice for the 4*sum total.
// ============================================================================
module cpc_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [cpc_pkg::DATA_W-1:0]  column_x,
    input  logic                        is_last,
    input  logic [cpc_pkg::DATA_W-1:0]  radius,
    input  logic [cpc_pkg::DATA_W-1:0]  modulus,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output cpc_pkg::cpc_result_t        res
);
    import cpc_pkg::*;

    localparam int RB = RADIUS_BITS;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PREP = 9'b000000010,
        ST_MUL  = 9'b000000100,
        ST_SQRT = 9'b000001000,
        ST_CEIL = 9'b000010000,
        ST_ADD  = 9'b000100000,
        ST_MOD  = 9'b001000000,
        ST_DBL  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic                last_reg, last_next;
    logic [RB-1:0]       a_reg, a_next;
    logic [RB:0]         b_reg, b_next;
    logic [2*RB-1:0]     d_reg, d_next;
    logic [RB-1:0]       root_reg, root_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [HEIGHT_W-1:0] h_reg, h_next;
    logic [DV_W-1:0]     dv_reg, dv_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [DATA_W-1:0]   k;
    logic [RB-1:0]       r_eff;
    logic [2*RB:0]       prod;
    logic [CSUB_W-1:0]   op_a, op_b, op_diff;
    logic                op_ge;
    logic [REM_W-1:0]    step_rem;
    logic                in_fire, res_fire;

    // Effective modulus and radius
    assign k     = (modulus == '0) ? DATA_W'(1) : modulus;
    assign r_eff = radius[RB-1:0];

    assign in_fire  = in_valid && (state_reg == ST_IDLE);
    assign res_fire = res_valid && res_ready;

    // r*r - x*x as one product
    assign prod = {{(RB+1){1'b0}}, a_reg} * {{RB{1'b0}}, b_reg};

    // Operand select for the shared unit
    always_comb
    begin
        case (state_reg)
            ST_SQRT:
            begin
                op_a = {rem_reg, d_reg[2*RB-1 -: 2]};
                op_b = CSUB_W'({root_reg, 2'b01});
            end
            ST_MOD:
            begin
                op_a = CSUB_W'({rem_reg, dv_reg[DV_W-1]});
                op_b = CSUB_W'(k);
            end
            default:
            begin
                op_a = CSUB_W'({rem_reg, 1'b0});
                op_b = CSUB_W'(k);
            end
        endcase
    end

    cpc_csub u_csub (
        .a    (op_a),
        .b    (op_b),
        .ge   (op_ge),
        .diff (op_diff)
    );

    assign step_rem = op_ge ? op_diff[REM_W-1:0] : op_a[REM_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        h_next     = h_reg;
        dv_next    = dv_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = column_x;
                    last_next  = is_last;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // Column at or beyond the radius has no height
                if (x_reg >= DATA_W'(r_eff))
                begin
                    h_next     = '0;
                    state_next = ST_ADD;
                end
                else
                begin
                    a_next     = r_eff - x_reg[RB-1:0];
                    b_next     = {1'b0, r_eff} + {1'b0, x_reg[RB-1:0]};
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                d_next     = prod[2*RB-1:0];
                root_next  = '0;
                rem_next   = '0;
                cnt_next   = CNT_W'(RB - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                d_next    = {d_reg[2*RB-3:0], 2'b00};
                rem_next  = step_rem;
                root_next = {root_reg[RB-2:0], op_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_CEIL;
                end
            end
            ST_CEIL:
            begin
                // Nonzero remainder means the root was not exact
                h_next     = HEIGHT_W'(root_reg) + HEIGHT_W'(rem_reg != '0);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                dv_next    = DV_W'(sum_reg) + DV_W'(h_reg);
                rem_next   = '0;
                cnt_next   = CNT_W'(MOD_STEPS - 1);
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                dv_next  = {dv_reg[DV_W-2:0], 1'b0};
                rem_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    sum_next   = step_rem[DATA_W-1:0];
                    cnt_next   = CNT_W'(DBL_STEPS - 1);
                    state_next = ST_DBL;
                end
            end
            ST_DBL:
            begin
                rem_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    if (last_reg)
                    begin
                        sum_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        h_reg    <= h_next;
        dv_reg   <= dv_next;
        cnt_reg  <= cnt_next;
    end

    assign idle       = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res.height = h_reg;
    assign res.total  = rem_reg[DATA_W-1:0];
    assign res.last   = last_reg;

`ifndef ASSERT_OFF
    // Reduced values stay below the modulus
    a_total_lt_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (rem_reg < REM_W'(k)))
        else $error("pixel total not reduced below modulus");

    a_sum_lt_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (sum_reg < k))
        else $error("running sum not reduced below modulus");

    // Rounded-up height never exceeds the radius range
    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (h_reg <= (HEIGHT_W'(1) << RB)))
        else $error("column height out of range");

    // Closing column clears the sum
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && last_reg) |=> (sum_reg == '0))
        else $error("sum not cleared after last column");

    // A delivered result returns the sequencer to idle
    a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle");
`endif

endmodule

>>> hdl/circle_pixel_counter.sv
// ============================================================================
// circle_pixel_counter: lattice pixel count of a circle, one column per item
// Configuration registers, input acceptance and the output register around
// the column sequencer.
// ============================================================================
// A column whose x lies inside the radius passes from its transfer through
// setup, multiply, 32 square root steps, round-up, add, 34 modulo steps and
// 2 doublings, then a hand-off to the output; the root, modulo and doubling
// steps go through one compare-subtract unit. A column at or beyond the
// radius skips the multiply and the root. One column is in work at a time;
// in_stall is high from the transfer until the result is handed to the
// output register, which holds it until taken so that the next column may
// start meanwhile. Configuration writes must go in only while no column is
// in work; the user must keep to this, the block does not enforce it.
module circle_pixel_counter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpc_pkg::DATA_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cpc_pkg::DATA_W-1:0]     column_x,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cpc_pkg::HEIGHT_W-1:0]   column_height,
    output logic [cpc_pkg::DATA_W-1:0]     pixel_total,
    output logic                           final_result
);
    import cpc_pkg::*;

    logic [DATA_W-1:0] radius_reg, radius_next;
    logic [DATA_W-1:0] modulus_reg, modulus_next;
    logic              out_valid_reg, out_valid_next;
    cpc_result_t       out_reg, out_next;
    cpc_result_t       seq_res;
    logic              seq_idle, seq_valid, seq_ready;

    // Register writes
    always_comb
    begin
        radius_next  = radius_reg;
        modulus_next = modulus_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_next  = cfg_data;
                REG_MODULUS: modulus_next = cfg_data;
                default:     ;
            endcase
        end
    end

    cpc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .column_x  (column_x),
        .is_last   (is_last),
        .radius    (radius_reg),
        .modulus   (modulus_reg),
        .idle      (seq_idle),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .res       (seq_res)
    );

    assign in_stall = ~seq_idle;

    // Output register: loads when empty or being emptied
    assign seq_ready = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (seq_valid && seq_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = seq_res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= '0;
            modulus_reg   <= DATA_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radius_reg    <= radius_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign column_height = out_reg.height;
    assign pixel_total   = out_reg.total;
    assign final_result  = out_reg.last;

endmodule
